// ===== hw/rtl/relative_head_pose_core_defines.svh =====
// Assertion macros shared by the relative head pose RTL.
`ifndef RELATIVE_HEAD_POSE_CORE_DEFINES_SVH
`define RELATIVE_HEAD_POSE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rhp_pkg.sv =====
// Shared types and constants of the relative head pose block.
`default_nettype none
package rhp_pkg;

    localparam int CNT_W = 32;
    localparam logic [1:0] TRK_BOTH = 2'b11;

    typedef struct packed {
        logic issue;
        logic clr;
        logic neg;
    } t_mac_cmd;

    typedef struct packed {
        logic sq_start;
        logic dv_start;
    } t_sd_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sd_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/relative_head_pose_core.sv =====
// Relative head pose: top level with sequencer, shared MAC and shared sqrt/divide.
// The shared sqrt/divide unit gives one result bit per cycle and normalises twice per sample.
// A dropped sample leaves the block idle and ready for the next one; one sample is in work at a time.
// The result register lets the next sample start while a result waits.
// Reset (synchronous, active low) clears the origin, the sample count and all handshakes.
`default_nettype none
`include "relative_head_pose_core_defines.svh"
module relative_head_pose_core #(
    parameter int POSITION_WIDTH = 32,
    parameter int QUAT_WIDTH     = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_recenter,
    input  logic [1:0]                       i_tracking_flags,
    input  logic signed [QUAT_WIDTH-1:0]     i_eye_quat_x,
    input  logic signed [QUAT_WIDTH-1:0]     i_eye_quat_y,
    input  logic signed [QUAT_WIDTH-1:0]     i_eye_quat_z,
    input  logic signed [QUAT_WIDTH-1:0]     i_eye_quat_w,
    input  logic signed [POSITION_WIDTH-1:0] i_left_pos_x,
    input  logic signed [POSITION_WIDTH-1:0] i_left_pos_y,
    input  logic signed [POSITION_WIDTH-1:0] i_left_pos_z,
    input  logic signed [POSITION_WIDTH-1:0] i_right_pos_x,
    input  logic signed [POSITION_WIDTH-1:0] i_right_pos_y,
    input  logic signed [POSITION_WIDTH-1:0] i_right_pos_z,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [POSITION_WIDTH-1:0] o_rel_pos_x,
    output logic signed [POSITION_WIDTH-1:0] o_rel_pos_y,
    output logic signed [POSITION_WIDTH-1:0] o_rel_pos_z,
    output logic signed [QUAT_WIDTH-1:0]     o_rel_quat_x,
    output logic signed [QUAT_WIDTH-1:0]     o_rel_quat_y,
    output logic signed [QUAT_WIDTH-1:0]     o_rel_quat_z,
    output logic signed [QUAT_WIDTH-1:0]     o_rel_quat_w,
    output logic [rhp_pkg::CNT_W-1:0]        o_sample_count,
    output logic                             o_origin_captured
);
    import rhp_pkg::*;

    localparam int PW   = POSITION_WIDTH;
    localparam int QW   = QUAT_WIDTH;
    localparam int QF   = QW - 2;
    localparam int NS   = 2 * QW - 1;
    localparam int XW   = 2 * NS;
    localparam int K    = QW;
    localparam int NW   = 3 * QW;
    localparam int SW   = 2 * QW + 1;
    localparam int BW   = PW + 5;
    localparam int AW   = QW + 1;
    localparam int ACCW = PW + QW + 8;

    localparam logic signed [ACCW-1:0] HALF = {{(ACCW-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};
    localparam logic signed [ACCW-1:0] Q_HI = {{(ACCW-QW+1){1'b0}}, {(QW-1){1'b1}}};
    localparam logic signed [ACCW-1:0] Q_LO = ~Q_HI;
    localparam logic signed [ACCW-1:0] P_HI = {{(ACCW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [ACCW-1:0] P_LO = ~P_HI;
    localparam logic signed [QW-1:0]   Q_ONE = {2'b01, {QF{1'b0}}};

    localparam logic [2:0] N_SQ   = 3'd4;
    localparam logic [2:0] N_PROD = 3'd4;
    localparam logic [2:0] N_TV   = 3'd2;
    localparam logic [2:0] N_ROT  = 3'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_DIV, S_CAP, S_PROD, S_TV, S_ROT, S_OUT
    } t_state;

    typedef enum logic [1:0] {B_C, B_N, B_D, B_T} t_bsrc;

    t_state                 r_state;
    logic [1:0]             r_idx;
    logic [2:0]             r_term;
    logic                   r_norm2;
    logic                   r_ov;
    logic                   r_cap;
    logic [CNT_W-1:0]       r_count;
    logic signed [QW-1:0]   r_c   [4];
    logic signed [QW-1:0]   r_n   [4];
    logic signed [QW-1:0]   r_oq  [4];
    logic signed [PW-1:0]   r_op  [3];
    logic signed [PW-1:0]   r_ctr [3];
    logic signed [BW-1:0]   r_d   [3];
    logic signed [BW-1:0]   r_t   [3];
    logic signed [PW-1:0]   r_res [3];
    logic                   r_ovld;
    logic signed [PW-1:0]   r_opos [3];
    logic signed [QW-1:0]   r_oqt  [4];
    logic [CNT_W-1:0]       r_ocnt;
    logic                   r_ocap;

    logic                   in_acc;
    logic                   out_load;
    logic                   mac_ph;
    logic                   wb;
    logic [1:0]             ta;
    logic [1:0]             tb;
    logic                   tneg;
    logic                   a_c;
    t_bsrc                  bsrc;
    logic [2:0]             nterm;
    logic [1:0]             c_sel;
    logic [1:0]             d_sel;
    logic signed [QW-1:0]   c_rd;
    logic signed [BW-1:0]   d_rd;
    logic signed [QW-1:0]   oq_rd;
    logic signed [AW-1:0]   mac_a;
    logic signed [BW-1:0]   mac_b;
    logic signed [ACCW-1:0] acc;
    t_mac_cmd               mac_cmd;
    t_sd_cmd                sd_cmd;
    t_sd_stat               sd_stat;
    logic [NS-1:0]          root;
    logic [K-1:0]           quot;
    logic [SW-1:0]          sum;
    logic [XW-1:0]          sq_x;
    logic                   c_neg;
    logic [QW-1:0]          c_mag;
    logic [NW-1:0]          dv_num;
    logic signed [ACCW-1:0] q_sgn;
    logic signed [ACCW-1:0] rnd_acc;
    logic signed [ACCW-1:0] rnd_t;
    logic signed [ACCW-1:0] d_ext;
    logic                   norm_done;

    function automatic logic signed [ACCW-1:0] f_rnd(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] m;
        logic signed [ACCW-1:0] r;
        m = v[ACCW-1] ? -v : v;
        r = (m + HALF) >>> QF;
        return v[ACCW-1] ? -r : r;
    endfunction

    function automatic logic signed [QW-1:0] f_clq(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] c;
        c = (v > Q_HI) ? Q_HI : ((v < Q_LO) ? Q_LO : v);
        return c[QW-1:0];
    endfunction

    function automatic logic signed [PW-1:0] f_clp(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] c;
        c = (v > P_HI) ? P_HI : ((v < P_LO) ? P_LO : v);
        return c[PW-1:0];
    endfunction

    function automatic logic signed [PW-1:0] f_ctr(input logic signed [PW-1:0] a,
                                                   input logic signed [PW-1:0] b);
        logic signed [PW:0] s;
        s = {a[PW-1], a} + {b[PW-1], b};
        return s[PW:1];
    endfunction

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_OUT) && (!r_ovld || !i_out_stall);

    // operand table: inv = conj(origin) on the A side
    always_comb begin
        ta    = 2'd0;
        tb    = 2'd0;
        tneg  = 1'b0;
        a_c   = 1'b0;
        bsrc  = B_N;
        nterm = N_PROD;
        case (r_state)
            S_SQ: begin
                nterm = N_SQ;
                a_c   = 1'b1;
                bsrc  = B_C;
            end
            S_PROD: begin
                nterm = N_PROD;
                bsrc  = B_N;
                case ({r_idx, r_term[1:0]})
                    4'b0000: begin ta = 2'd3; tb = 2'd0; end
                    4'b0001: begin ta = 2'd0; tb = 2'd3; end
                    4'b0010: begin ta = 2'd1; tb = 2'd2; end
                    4'b0011: begin ta = 2'd2; tb = 2'd1; tneg = 1'b1; end
                    4'b0100: begin ta = 2'd3; tb = 2'd1; end
                    4'b0101: begin ta = 2'd0; tb = 2'd2; tneg = 1'b1; end
                    4'b0110: begin ta = 2'd1; tb = 2'd3; end
                    4'b0111: begin ta = 2'd2; tb = 2'd0; end
                    4'b1000: begin ta = 2'd3; tb = 2'd2; end
                    4'b1001: begin ta = 2'd0; tb = 2'd1; end
                    4'b1010: begin ta = 2'd1; tb = 2'd0; tneg = 1'b1; end
                    4'b1011: begin ta = 2'd2; tb = 2'd3; end
                    4'b1100: begin ta = 2'd3; tb = 2'd3; end
                    4'b1101: begin ta = 2'd0; tb = 2'd0; tneg = 1'b1; end
                    4'b1110: begin ta = 2'd1; tb = 2'd1; tneg = 1'b1; end
                    4'b1111: begin ta = 2'd2; tb = 2'd2; tneg = 1'b1; end
                    default: ;
                endcase
            end
            S_TV: begin
                nterm = N_TV;
                bsrc  = B_D;
                case ({r_idx, r_term[0]})
                    3'b000:  begin ta = 2'd1; tb = 2'd2; end
                    3'b001:  begin ta = 2'd2; tb = 2'd1; tneg = 1'b1; end
                    3'b010:  begin ta = 2'd2; tb = 2'd0; end
                    3'b011:  begin ta = 2'd0; tb = 2'd2; tneg = 1'b1; end
                    3'b100:  begin ta = 2'd0; tb = 2'd1; end
                    3'b101:  begin ta = 2'd1; tb = 2'd0; tneg = 1'b1; end
                    default: ;
                endcase
            end
            S_ROT: begin
                nterm = N_ROT;
                bsrc  = B_T;
                case ({r_idx, r_term[1:0]})
                    4'b0000: begin ta = 2'd3; tb = 2'd0; end
                    4'b0001: begin ta = 2'd1; tb = 2'd2; end
                    4'b0010: begin ta = 2'd2; tb = 2'd1; tneg = 1'b1; end
                    4'b0100: begin ta = 2'd3; tb = 2'd1; end
                    4'b0101: begin ta = 2'd2; tb = 2'd0; end
                    4'b0110: begin ta = 2'd0; tb = 2'd2; tneg = 1'b1; end
                    4'b1000: begin ta = 2'd3; tb = 2'd2; end
                    4'b1001: begin ta = 2'd0; tb = 2'd1; end
                    4'b1010: begin ta = 2'd1; tb = 2'd0; tneg = 1'b1; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign mac_ph = (r_state == S_SQ) || (r_state == S_PROD) ||
                    (r_state == S_TV) || (r_state == S_ROT);
    assign wb     = mac_ph && (r_term == nterm + 3'd1);

    assign c_sel = (r_state == S_SQ) ? r_term[1:0] : r_idx;
    assign d_sel = (r_state == S_TV) ? tb : r_idx;
    assign c_rd  = r_c[c_sel];
    assign d_rd  = r_d[d_sel];
    assign oq_rd = r_oq[ta];

    always_comb begin
        if (a_c) begin
            mac_a = {c_rd[QW-1], c_rd};
        end else if (ta == 2'd3) begin
            mac_a = {oq_rd[QW-1], oq_rd};
        end else begin
            mac_a = -{oq_rd[QW-1], oq_rd};
        end
        case (bsrc)
            B_C:     mac_b = {{(BW-QW){c_rd[QW-1]}}, c_rd};
            B_N:     mac_b = {{(BW-QW){r_n[tb][QW-1]}}, r_n[tb]};
            B_D:     mac_b = d_rd;
            B_T:     mac_b = r_t[tb];
            default: mac_b = '0;
        endcase
    end

    assign mac_cmd.issue = mac_ph && (r_term < nterm);
    assign mac_cmd.clr   = (r_term == 3'd0);
    assign mac_cmd.neg   = tneg;

    rhp_mac #(
        .A_W   (AW),
        .B_W   (BW),
        .ACC_W (ACCW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    // normalisation arithmetic
    assign sum    = acc[SW-1:0];
    assign sq_x   = {{(XW-SW){1'b0}}, sum} << (2 * QF);
    assign c_neg  = c_rd[QW-1];
    assign c_mag  = c_neg ? QW'(-{c_rd[QW-1], c_rd}) : c_rd;
    assign dv_num = ({{(NW-QW){1'b0}}, c_mag} << (2 * QF)) + ({{(NW-NS){1'b0}}, root} >> 1);
    assign q_sgn  = c_neg ? -{{(ACCW-K){1'b0}}, quot} : {{(ACCW-K){1'b0}}, quot};

    assign sd_cmd.sq_start = (r_state == S_SQ) && wb && (sum != '0);
    assign sd_cmd.dv_start = (r_state == S_DIV) && (r_term == 3'd0);

    rhp_sqdiv #(
        .NS    (NS),
        .K     (K),
        .NUM_W (NW)
    ) u_sqdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (sd_cmd),
        .i_sq_x   (sq_x),
        .i_dv_num (dv_num),
        .o_root   (root),
        .o_quot   (quot),
        .o_stat   (sd_stat)
    );

    assign rnd_acc = f_rnd(acc);
    assign rnd_t   = f_rnd(acc <<< 1);
    assign d_ext   = ACCW'(d_rd);

    assign norm_done = ((r_state == S_SQ) && wb && (sum == '0)) ||
                       ((r_state == S_DIV) && (r_term != 3'd0) && sd_stat.done &&
                        (r_idx == 2'd3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_term  <= '0;
            r_norm2 <= 1'b0;
            r_ov    <= 1'b0;
            r_cap   <= 1'b0;
            r_count <= '0;
            r_ovld  <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                r_op[j] <= '0;
                r_oq[j] <= '0;
            end
            r_oq[3] <= Q_ONE;
        end else begin
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_ovld <= 1'b0;
            end
            if (mac_ph && !wb) begin
                r_term <= r_term + 3'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_recenter) begin
                            r_ov <= 1'b0;
                        end
                        if (i_tracking_flags == TRK_BOTH) begin
                            r_c[0]   <= i_eye_quat_x;
                            r_c[1]   <= i_eye_quat_y;
                            r_c[2]   <= i_eye_quat_z;
                            r_c[3]   <= i_eye_quat_w;
                            r_ctr[0] <= f_ctr(i_left_pos_x, i_right_pos_x);
                            r_ctr[1] <= f_ctr(i_left_pos_y, i_right_pos_y);
                            r_ctr[2] <= f_ctr(i_left_pos_z, i_right_pos_z);
                            r_cap    <= 1'b0;
                            r_norm2  <= 1'b0;
                            r_idx    <= '0;
                            r_term   <= '0;
                            r_state  <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    if (wb) begin
                        r_term <= '0;
                        r_idx  <= '0;
                        if (sum == '0) begin
                            // all-zero quaternion maps to identity
                            r_n[0]  <= '0;
                            r_n[1]  <= '0;
                            r_n[2]  <= '0;
                            r_n[3]  <= Q_ONE;
                            r_state <= r_norm2 ? S_TV : S_CAP;
                        end else begin
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (sd_stat.done) begin
                        r_term  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_term == 3'd0) begin
                        r_term <= 3'd1;
                    end else if (sd_stat.done) begin
                        // index wraps to zero after the last component
                        r_n[r_idx] <= f_clq(q_sgn);
                        r_term     <= '0;
                        r_idx      <= r_idx + 2'd1;
                        if (norm_done) begin
                            r_state <= r_norm2 ? S_TV : S_CAP;
                        end
                    end
                end
                S_CAP: begin
                    for (int j = 0; j < 3; j++) begin
                        if (!r_ov) begin
                            r_op[j] <= r_ctr[j];
                            r_d[j]  <= '0;
                        end else begin
                            r_d[j] <= BW'(r_ctr[j]) - BW'(r_op[j]);
                        end
                    end
                    if (!r_ov) begin
                        for (int j = 0; j < 4; j++) begin
                            r_oq[j] <= r_n[j];
                        end
                        r_ov  <= 1'b1;
                        r_cap <= 1'b1;
                    end
                    r_idx   <= '0;
                    r_term  <= '0;
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    if (wb) begin
                        r_c[r_idx] <= f_clq(rnd_acc);
                        r_term     <= '0;
                        r_idx      <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            r_norm2 <= 1'b1;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_TV: begin
                    if (wb) begin
                        r_t[r_idx] <= rnd_t[BW-1:0];
                        r_term     <= '0;
                        r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                        if (r_idx == 2'd2) begin
                            r_state <= S_ROT;
                        end
                    end
                end
                S_ROT: begin
                    if (wb) begin
                        r_res[r_idx] <= f_clp(d_ext + rnd_acc);
                        r_term       <= '0;
                        r_idx        <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                        if (r_idx == 2'd2) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (out_load) begin
            for (int j = 0; j < 3; j++) begin
                r_opos[j] <= r_res[j];
            end
            for (int j = 0; j < 4; j++) begin
                r_oqt[j] <= r_n[j];
            end
            r_ocnt <= r_count + CNT_W'(1);
            r_ocap <= r_cap;
        end
    end

    assign o_out_valid       = r_ovld;
    assign o_rel_pos_x       = r_opos[0];
    assign o_rel_pos_y       = r_opos[1];
    assign o_rel_pos_z       = r_opos[2];
    assign o_rel_quat_x      = r_oqt[0];
    assign o_rel_quat_y      = r_oqt[1];
    assign o_rel_quat_z      = r_oqt[2];
    assign o_rel_quat_w      = r_oqt[3];
    assign o_sample_count    = r_ocnt;
    assign o_origin_captured = r_ocap;

    `RHP_ASSERT_NXT(a_drop_no_work, i_clk, i_rst_n, in_acc && (i_tracking_flags != TRK_BOTH), r_state == S_IDLE, "dropped transaction started work")
    `RHP_ASSERT_NXT(a_cap_origin, i_clk, i_rst_n, (r_state == S_CAP) && !r_ov, r_ov && r_cap, "origin not captured")
    `RHP_ASSERT_NXT(a_out_load, i_clk, i_rst_n, out_load, o_out_valid && r_ov && (r_state == S_IDLE), "result load inconsistent")
    `RHP_ASSERT_IMP(a_sd_quiet, i_clk, i_rst_n, sd_stat.busy, (r_state == S_SQRT) || (r_state == S_DIV), "sqrt/divide running outside its phase")

endmodule
`default_nettype wire

// ===== hw/rtl/rhp_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulate.
`default_nettype none
module rhp_mac #(
    parameter int A_W   = 17,
    parameter int B_W   = 37,
    parameter int ACC_W = 56
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rhp_pkg::t_mac_cmd       i_cmd,
    input  logic signed [A_W-1:0]   i_a,
    input  logic signed [B_W-1:0]   i_b,
    output logic signed [ACC_W-1:0] o_acc
);
    import rhp_pkg::*;

    logic signed [A_W+B_W-1:0] r_prod;
    logic                      r_v;
    logic                      r_clr;
    logic                      r_neg;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   n_acc;

    assign prod_ext = ACC_W'(r_prod);
    assign n_acc    = (r_clr ? '0 : r_acc) + (r_neg ? -prod_ext : prod_ext);
    assign o_acc    = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_cmd.issue;
        end
        r_prod <= i_a * i_b;
        r_clr  <= i_cmd.clr;
        r_neg  <= i_cmd.neg;
        if (r_v) begin
            r_acc <= n_acc;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rhp_sqdiv.sv =====
// Shared radix-2 unit: integer square root, then divisions by that root.
`default_nettype none
module rhp_sqdiv #(
    parameter int NS    = 31,
    parameter int K     = 16,
    parameter int NUM_W = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rhp_pkg::t_sd_cmd   i_cmd,
    input  logic [2*NS-1:0]    i_sq_x,
    input  logic [NUM_W-1:0]   i_dv_num,
    output logic [NS-1:0]      o_root,
    output logic [K-1:0]       o_quot,
    output rhp_pkg::t_sd_stat  o_stat
);
    import rhp_pkg::*;

    localparam int XW = 2 * NS;
    localparam int RW = NS + 4;
    localparam int CW = $clog2(NS + 1);

    logic [XW-1:0]    r_x;
    logic [RW-1:0]    r_rem;
    logic [NS-1:0]    r_root;
    logic [K-1:0]     r_q;
    logic [CW-1:0]    r_cnt;
    logic             r_sq;
    logic             r_done;
    logic [RW-1:0]    rs;
    logic [RW-1:0]    rd;
    logic [RW-1:0]    opnd;
    logic [RW-1:0]    subtr;
    logic [RW:0]      diff;
    logic             ge;
    logic [NUM_W-1:0] num_sh;

    assign rs     = {r_rem[RW-3:0], r_x[XW-1:XW-2]};
    assign rd     = {r_rem[RW-2:0], r_x[XW-1]};
    assign opnd   = r_sq ? rs : rd;
    // sqrt trial is 4*root+1; division subtracts the root itself
    assign subtr  = r_sq ? {2'b00, r_root, 2'b01} : {4'b0000, r_root};
    assign diff   = {1'b0, opnd} - {1'b0, subtr};
    assign ge     = !diff[RW];
    assign num_sh = i_dv_num >> K;

    assign o_root      = r_root;
    assign o_quot      = r_q;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_cmd.sq_start) begin
                r_cnt <= CW'(NS);
            end else if (i_cmd.dv_start) begin
                r_cnt <= CW'(K);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (i_cmd.sq_start) begin
            r_x    <= i_sq_x;
            r_rem  <= '0;
            r_root <= '0;
            r_sq   <= 1'b1;
        end else if (i_cmd.dv_start) begin
            // quotient is known to fit K bits, so the upper part is below the root
            r_rem <= num_sh[RW-1:0];
            r_x   <= {i_dv_num[K-1:0], {(XW-K){1'b0}}};
            r_q   <= '0;
            r_sq  <= 1'b0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[RW-1:0] : opnd;
            if (r_sq) begin
                r_root <= {r_root[NS-2:0], ge};
                r_x    <= r_x << 2;
            end else begin
                r_q <= {r_q[K-2:0], ge};
                r_x <= r_x << 1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_relative_head_pose_core.sv =====
// Self-checking testbench for relative_head_pose_core: directed table, then random samples.
`timescale 1ns / 1ps
module tb_relative_head_pose_core;
    import rhp_pkg::*;

    localparam int QF = 14;
    localparam int N_RANDOM = 1430;
    localparam int WDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 600;

    typedef longint q4_t[4];
    typedef longint v3_t[3];

    typedef struct {
        bit                recenter;
        bit [1:0]          flags;
        bit signed [15:0]  q[4];
        bit signed [31:0]  lp[3];
        bit signed [31:0]  rp[3];
    } sample_t;

    typedef struct {
        bit signed [31:0]  pos[3];
        bit signed [15:0]  quat[4];
        bit [31:0]         count;
        bit                captured;
    } pose_t;

    typedef struct {
        sample_t s;
        bit      typed;
        pose_t   want;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    logic i_recenter = 1'b0;
    logic [1:0] i_tracking_flags = '0;
    logic signed [15:0] i_eye_quat_x = '0, i_eye_quat_y = '0, i_eye_quat_z = '0, i_eye_quat_w = '0;
    logic signed [31:0] i_left_pos_x = '0, i_left_pos_y = '0, i_left_pos_z = '0;
    logic signed [31:0] i_right_pos_x = '0, i_right_pos_y = '0, i_right_pos_z = '0;
    wire o_in_stall, o_out_valid, o_origin_captured;
    wire signed [31:0] o_rel_pos_x, o_rel_pos_y, o_rel_pos_z;
    wire signed [15:0] o_rel_quat_x, o_rel_quat_y, o_rel_quat_z, o_rel_quat_w;
    wire [CNT_W-1:0] o_sample_count;

    relative_head_pose_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_recenter(i_recenter), .i_tracking_flags(i_tracking_flags),
        .i_eye_quat_x(i_eye_quat_x), .i_eye_quat_y(i_eye_quat_y),
        .i_eye_quat_z(i_eye_quat_z), .i_eye_quat_w(i_eye_quat_w),
        .i_left_pos_x(i_left_pos_x), .i_left_pos_y(i_left_pos_y), .i_left_pos_z(i_left_pos_z),
        .i_right_pos_x(i_right_pos_x), .i_right_pos_y(i_right_pos_y),
        .i_right_pos_z(i_right_pos_z),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_rel_pos_x(o_rel_pos_x), .o_rel_pos_y(o_rel_pos_y), .o_rel_pos_z(o_rel_pos_z),
        .o_rel_quat_x(o_rel_quat_x), .o_rel_quat_y(o_rel_quat_y),
        .o_rel_quat_z(o_rel_quat_z), .o_rel_quat_w(o_rel_quat_w),
        .o_sample_count(o_sample_count), .o_origin_captured(o_origin_captured)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    longint org_pos[3];
    longint org_quat[4];
    bit     org_valid;
    bit [31:0] pose_count;

    pose_t  pending_poses[$];
    int     n_errors = 0;
    int     idle_cycles = 0;
    bit     quiet = 1'b0;
    bit     hold_rx = 1'b0;
    row_t   dir_rows[$];

    function automatic longint rnd_shr(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint sat(longint v, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic q4_t unit_quat(q4_t c);
        q4_t o;
        longint unsigned sum, len, mag, qv;
        sum = 0;
        for (int i = 0; i < 4; i++) sum += longint'(c[i] * c[i]);
        if (sum == 0) begin
            o = '{0, 0, 0, 1 << QF};
            return o;
        end
        len = int_sqrt(sum << (2 * QF));
        for (int i = 0; i < 4; i++) begin
            mag = (c[i] < 0) ? -c[i] : c[i];
            qv = ((mag << (2 * QF)) + len / 2) / len;
            o[i] = sat((c[i] < 0) ? -longint'(qv) : longint'(qv), 16);
        end
        return o;
    endfunction

    function automatic q4_t quat_mul(q4_t a, q4_t b);
        q4_t p;
        p[0] = a[3] * b[0] + a[0] * b[3] + a[1] * b[2] - a[2] * b[1];
        p[1] = a[3] * b[1] - a[0] * b[2] + a[1] * b[3] + a[2] * b[0];
        p[2] = a[3] * b[2] + a[0] * b[1] - a[1] * b[0] + a[2] * b[3];
        p[3] = a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2];
        for (int i = 0; i < 4; i++) p[i] = sat(rnd_shr(p[i], QF), 16);
        return unit_quat(p);
    endfunction

    // v + w t + q x t, with t = 2 (q x v)
    function automatic v3_t rotate(q4_t q, v3_t v);
        v3_t o;
        longint t0, t1, t2;
        t0 = rnd_shr(2 * (q[1] * v[2] - q[2] * v[1]), QF);
        t1 = rnd_shr(2 * (q[2] * v[0] - q[0] * v[2]), QF);
        t2 = rnd_shr(2 * (q[0] * v[1] - q[1] * v[0]), QF);
        o[0] = sat(v[0] + rnd_shr(q[3] * t0 + q[1] * t2 - q[2] * t1, QF), 32);
        o[1] = sat(v[1] + rnd_shr(q[3] * t1 + q[2] * t0 - q[0] * t2, QF), 32);
        o[2] = sat(v[2] + rnd_shr(q[3] * t2 + q[0] * t1 - q[1] * t0, QF), 32);
        return o;
    endfunction

    // returns 1 and fills the pose when the sample is used
    function automatic bit predict_pose(sample_t s, output pose_t p);
        q4_t raw, cur, inv, rel;
        v3_t centre, delta, rv;
        if (s.recenter) org_valid = 1'b0;
        if (s.flags != TRK_BOTH) return 1'b0;
        for (int i = 0; i < 4; i++) raw[i] = s.q[i];
        cur = unit_quat(raw);
        for (int i = 0; i < 3; i++) centre[i] = (longint'(s.lp[i]) + longint'(s.rp[i])) >>> 1;
        p.captured = !org_valid;
        if (!org_valid) begin
            org_pos = centre;
            org_quat = cur;
            org_valid = 1'b1;
        end
        for (int i = 0; i < 3; i++) inv[i] = -org_quat[i];
        inv[3] = org_quat[3];
        rel = quat_mul(inv, cur);
        for (int i = 0; i < 3; i++) delta[i] = centre[i] - org_pos[i];
        rv = rotate(inv, delta);
        pose_count = pose_count + 1;
        for (int i = 0; i < 3; i++) p.pos[i] = rv[i];
        for (int i = 0; i < 4; i++) p.quat[i] = rel[i];
        p.count = pose_count;
        return 1'b1;
    endfunction

    function automatic bit signed [15:0] rand_quat_part(int mode);
        case (mode)
            0: return '0;
            1: return $urandom_range(0, 32767) - 16384;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit signed [31:0] rand_pos(int mode);
        case (mode)
            0: return $urandom_range(0, 262143) - 131072;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 15)
                                           : 32'sh80000000 + $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        int qm, pm;
        s.recenter = ($urandom_range(0, 19) == 0);
        s.flags = ($urandom_range(0, 4) != 0) ? TRK_BOTH : 2'($urandom_range(0, 3));
        qm = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 2);
        pm = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 4) == 0 ? 1 : 2);
        for (int i = 0; i < 4; i++) s.q[i] = rand_quat_part(qm);
        for (int i = 0; i < 3; i++) begin
            s.lp[i] = rand_pos(pm);
            s.rp[i] = rand_pos(pm);
        end
        return s;
    endfunction

    function automatic sample_t mk(bit rc, bit [1:0] fl, int qx, int qy, int qz, int qw,
                                   int pl, int pr);
        sample_t s;
        s.recenter = rc;
        s.flags = fl;
        s.q = '{16'(qx), 16'(qy), 16'(qz), 16'(qw)};
        s.lp = '{pl, pl, pl};
        s.rp = '{pr, pr, pr};
        return s;
    endfunction

    function automatic row_t plain(sample_t s);
        row_t r;
        r.s = s;
        r.typed = 1'b0;
        return r;
    endfunction

    // sender: drives at the falling edge, one transaction at a time
    task automatic send_sample(sample_t s, int gap);
        pose_t p;
        row_t dummy;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_recenter <= s.recenter;
        i_tracking_flags <= s.flags;
        {i_eye_quat_x, i_eye_quat_y, i_eye_quat_z, i_eye_quat_w} <= {s.q[0], s.q[1], s.q[2], s.q[3]};
        {i_left_pos_x, i_left_pos_y, i_left_pos_z} <= {s.lp[0], s.lp[1], s.lp[2]};
        {i_right_pos_x, i_right_pos_y, i_right_pos_z} <= {s.rp[0], s.rp[1], s.rp[2]};
        do @(posedge i_clk); while (o_in_stall);
        if (predict_pose(s, p)) pending_poses.push_back(p);
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        pose_t w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_poses.size() == 0) begin
                $error("result transaction with nothing expected");
                n_errors++;
            end else begin
                w = pending_poses.pop_front();
                check_field("rel_pos_x", w.pos[0], o_rel_pos_x);
                check_field("rel_pos_y", w.pos[1], o_rel_pos_y);
                check_field("rel_pos_z", w.pos[2], o_rel_pos_z);
                check_field("rel_quat_x", w.quat[0], o_rel_quat_x);
                check_field("rel_quat_y", w.quat[1], o_rel_quat_y);
                check_field("rel_quat_z", w.quat[2], o_rel_quat_z);
                check_field("rel_quat_w", w.quat[3], o_rel_quat_w);
                check_field("sample_count", w.count, o_sample_count);
                check_field("origin_captured", w.captured, o_origin_captured);
            end
        end
    end

    // receiver stall bursts, plus one long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_out_stall <= 1'b1;
                repeat (900) @(negedge i_clk);
                hold_rx = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        row_t r;
        sample_t s;
        org_pos = '{0, 0, 0};
        org_quat = '{0, 0, 0, 1 << QF};
        org_valid = 1'b0;
        pose_count = '0;

        // all-zero quaternion at reset gives identity and becomes the origin
        r = plain(mk(0, TRK_BOTH, 0, 0, 0, 0, 0, 0));
        r.typed = 1'b1;
        r.want.pos = '{0, 0, 0};
        r.want.quat = '{0, 0, 0, 16384};
        r.want.count = 1;
        r.want.captured = 1'b1;
        dir_rows.push_back(r);
        dir_rows.push_back(plain(mk(0, 2'b00, 1, 2, 3, 4, 5, 6)));
        dir_rows.push_back(plain(mk(0, 2'b01, 1, 2, 3, 4, 5, 6)));
        // recenter on a dropped sample still clears the origin
        dir_rows.push_back(plain(mk(1, 2'b10, 1, 2, 3, 4, 5, 6)));
        r = plain(mk(0, TRK_BOTH, 16384, 0, 0, 0, 0, 0));
        r.typed = 1'b1;
        r.want.pos = '{0, 0, 0};
        r.want.quat = '{0, 0, 0, 16384};
        r.want.count = 2;
        r.want.captured = 1'b1;
        dir_rows.push_back(r);
        dir_rows.push_back(plain(mk(0, TRK_BOTH, 32767, 32767, 32767, 32767,
                                    32'h7fffffff, 32'h7fffffff)));
        dir_rows.push_back(plain(mk(0, TRK_BOTH, -32768, -32768, -32768, -32768,
                                    32'h80000000, 32'h80000000)));
        dir_rows.push_back(plain(mk(0, TRK_BOTH, -32768, 32767, 0, 0,
                                    32'h7fffffff, 32'h80000000)));
        dir_rows.push_back(plain(mk(0, TRK_BOTH, 0, 0, 0, 0, -3, 0)));
        // recenter with a used sample: cleared then captured from it
        dir_rows.push_back(plain(mk(1, TRK_BOTH, 0, 11585, 0, 11585, 65536, -65536)));
        dir_rows.push_back(plain(mk(0, TRK_BOTH, 0, 0, 16384, 0, 32'h80000000, 32'h80000000)));
        dir_rows.push_back(plain(mk(0, TRK_BOTH, 1, 0, 0, 0, 32'h7fffffff, 32'h7fffffff)));
        dir_rows.push_back(plain(mk(1, TRK_BOTH, -32768, 0, 0, 32767, 32'h7fffffff, 32'h7fffffff)));
        dir_rows.push_back(plain(mk(0, TRK_BOTH, 32767, 0, 0, -32768, 32'h80000000, 32'h80000000)));
        dir_rows.push_back(plain(mk(0, TRK_BOTH, 0, 0, 0, -1, 1, 0)));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            if (r.typed) begin
                send_sample(r.s, 0);
                // the typed expectation stands in place of the predicted one
                void'(pending_poses.pop_back());
                pending_poses.push_back(r.want);
            end else begin
                send_sample(r.s, $urandom_range(0, 1) ? 0 : $urandom_range(1, 7));
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) hold_rx = 1'b1;
            if (n == 500 || n == 900) begin
                i_in_valid <= 1'b0;
                while (pending_poses.size() != 0) @(negedge i_clk);
            end
            if (n == N_RANDOM - 150) quiet = 1'b1;
            s = rand_sample();
            if (!quiet && $urandom_range(0, 3) == 0)
                send_sample(s, $urandom_range(1, 7));
            else
                send_sample(s, 0);
        end
        i_in_valid <= 1'b0;

        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
